### hdl/eps_pkg.sv
// Shared types and constants of the exposure profile splitter.
package eps_pkg;

  localparam int unsigned TIME_W = 24;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned EV_W   = 32;
  localparam int unsigned DIVD_W = 40;
  localparam int unsigned DIVS_W = 24;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SPLIT = 1'b1;

  localparam logic [2:0] REG_FIXED_TIME  = 3'd0;
  localparam logic [2:0] REG_FIXED_GAIN  = 3'd1;
  localparam logic [2:0] REG_FLICKER     = 3'd2;
  localparam logic [2:0] REG_MIN_TIME    = 3'd3;
  localparam logic [2:0] REG_MAX_TIME    = 3'd4;
  localparam logic [2:0] REG_MIN_GAIN    = 3'd5;
  localparam logic [2:0] REG_STAGES      = 3'd6;

  typedef struct packed {
    logic              command;
    logic [2:0]        stage_index;
    logic [TIME_W-1:0] stage_time;
    logic [GAIN_W-1:0] stage_gain;
    logic [EV_W-1:0]   exposure_value;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] exposure_time;
    logic [GAIN_W-1:0] analogue_gain;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHK,
    ST_LOOP,
    ST_TRD,
    ST_TS,
    ST_GS,
    ST_DIVT,
    ST_DIVG,
    ST_FLK,
    ST_FDIV1,
    ST_FMUL,
    ST_FMUL2,
    ST_FDIV2,
    ST_OUT
  } state_e;

endpackage

### hdl/eps_div.sv
// Iterative restoring divider, one quotient bit per cycle, zero divisor gives zero.
module eps_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  eps_pkg::div_req_t req_i,
  output eps_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(eps_pkg::DIVD_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic                        zero_q, zero_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [eps_pkg::DIVD_W-1:0]  quo_q, quo_d;
  logic [eps_pkg::DIVS_W-1:0]  rem_q, rem_d;
  logic [eps_pkg::DIVS_W-1:0]  dvs_q, dvs_d;
  logic [eps_pkg::DIVS_W:0]    shifted;
  logic [eps_pkg::DIVS_W:0]    diff;

  assign shifted = {rem_q, quo_q[eps_pkg::DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      zero_d = (req_i.divisor == '0);
      cnt_d  = CW'(eps_pkg::DIVD_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // A borrow out of the top bit means the divisor did not fit.
      if (!diff[eps_pkg::DIVS_W]) begin
        rem_d = diff[eps_pkg::DIVS_W-1:0];
        quo_d = {quo_q[eps_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[eps_pkg::DIVS_W-1:0];
        quo_d = {quo_q[eps_pkg::DIVD_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = zero_q ? '0 : quo_q;

endmodule

### hdl/exposure_profile_splitter_core.sv
// Top level of the exposure profile splitter: registers, profile store and sequencer.
//
// Usage: items arrive on the input channel (in_valid_i, in_stall_o, in_item_i).
// A load item (command 0) writes one profile stage and produces no result.
// A split item (command 1) produces exactly one result item on the output
// channel (out_valid_o, out_stall_i, out_item_o). A split walks the profile
// stage by stage through a single shared 24x24 multiplier and uses one shared
// 40/24-bit divider for the division that can end the walk and for two more
// when flicker avoidance rounds the time. The block takes one item at a time:
// in_stall_o is high while a split runs. The finished result sits in an output
// register; the block accepts the next item while it waits, and a new result
// waits while out_stall_i holds the older one. Reset loads the register
// defaults and empties the output register; the profile store holds no defined
// value until stages are loaded. The user must write configuration through the
// APB port only while the block is idle; the block does not enforce it.
module exposure_profile_splitter_core #(
  parameter int unsigned MAX_STAGES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  eps_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output eps_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IDXW = $clog2(MAX_STAGES);
  localparam int unsigned CNTW = $clog2(MAX_STAGES + 1);
  localparam int unsigned TW   = eps_pkg::TIME_W;
  localparam int unsigned GW   = eps_pkg::GAIN_W;

  // Configuration registers.
  logic [TW-1:0] fixed_time_q, flicker_q, min_time_q, max_time_q;
  logic [GW-1:0] fixed_gain_q, min_gain_q;
  logic [3:0]    stages_q;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_time_q <= '0;
      fixed_gain_q <= '0;
      flicker_q    <= '0;
      min_time_q   <= '0;
      max_time_q   <= '1;
      min_gain_q   <= GW'(256);
      stages_q     <= 4'd2;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        eps_pkg::REG_FIXED_TIME: fixed_time_q <= pwdata[TW-1:0];
        eps_pkg::REG_FIXED_GAIN: fixed_gain_q <= pwdata[GW-1:0];
        eps_pkg::REG_FLICKER:    flicker_q    <= pwdata[TW-1:0];
        eps_pkg::REG_MIN_TIME:   min_time_q   <= pwdata[TW-1:0];
        eps_pkg::REG_MAX_TIME:   max_time_q   <= pwdata[TW-1:0];
        eps_pkg::REG_MIN_GAIN:   min_gain_q   <= pwdata[GW-1:0];
        eps_pkg::REG_STAGES:     stages_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eps_pkg::REG_FIXED_TIME: prdata = 32'(fixed_time_q);
      eps_pkg::REG_FIXED_GAIN: prdata = 32'(fixed_gain_q);
      eps_pkg::REG_FLICKER:    prdata = 32'(flicker_q);
      eps_pkg::REG_MIN_TIME:   prdata = 32'(min_time_q);
      eps_pkg::REG_MAX_TIME:   prdata = 32'(max_time_q);
      eps_pkg::REG_MIN_GAIN:   prdata = 32'(min_gain_q);
      eps_pkg::REG_STAGES:     prdata = 32'(stages_q);
      default:                 prdata = '0;
    endcase
  end

  // Zero passes through the limits untouched. With inverted limits the
  // minimum check wins because it is tested first.
  function automatic logic [TW-1:0] limit_time(input logic [TW-1:0] t,
                                               input logic [TW-1:0] lo,
                                               input logic [TW-1:0] hi);
    logic [TW-1:0] r;
    if (t == '0)     r = '0;
    else if (t < lo) r = lo;
    else if (t > hi) r = hi;
    else             r = t;
    return r;
  endfunction

  function automatic logic [GW-1:0] limit_gain(input logic [GW-1:0] g,
                                               input logic [GW-1:0] lo);
    logic [GW-1:0] r;
    if (g == '0)     r = '0;
    else if (g < lo) r = lo;
    else             r = g;
    return r;
  endfunction

  // Profile store: one row per stage, read at one address chosen by the sequencer.
  logic [TW-1:0]   prof_time_q [MAX_STAGES];
  logic [GW-1:0]   prof_gain_q [MAX_STAGES];
  logic [IDXW-1:0] rd_addr;
  logic [TW-1:0]   rd_time;
  logic [GW-1:0]   rd_gain;

  eps_pkg::state_e state_q, state_d;
  logic            in_acc;
  logic            load_wr;

  assign in_stall_o = (state_q != eps_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_wr    = in_acc && (in_item_i.command == eps_pkg::CMD_LOAD) &&
                      (32'(in_item_i.stage_index) < MAX_STAGES);

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      prof_time_q[IDXW'(in_item_i.stage_index)] <= in_item_i.stage_time;
      prof_gain_q[IDXW'(in_item_i.stage_index)] <= in_item_i.stage_gain;
    end
  end

  assign rd_time = prof_time_q[rd_addr];
  assign rd_gain = prof_gain_q[rd_addr];

  // Stage count clamped to the supported range.
  logic [CNTW-1:0] nst;
  logic [IDXW-1:0] last_idx;

  always_comb begin
    if (stages_q < 4'd2)                nst = CNTW'(2);
    else if (32'(stages_q) > MAX_STAGES) nst = CNTW'(MAX_STAGES);
    else                                nst = CNTW'(stages_q);
  end
  assign last_idx = IDXW'(nst - 1'b1);

  // Working registers of a split.
  logic [31:0]     ev_q, ev_d;
  logic [TW-1:0]   t_q, t_d, st_q, st_d, ft_q, ft_d, per_q, per_d, nt_q, nt_d;
  logic [GW-1:0]   g_q, g_d, last_q, last_d;
  logic [CNTW-1:0] s_q, s_d;
  logic            ft_nz, fg_nz;

  assign ft_nz = (ft_q != '0);
  assign fg_nz = (fixed_gain_q != '0);

  // The one shared multiplier.
  logic [TW-1:0]   mul_a, mul_b;
  logic [2*TW-1:0] prod;
  logic            reached;

  always_comb begin
    unique case (state_q)
      eps_pkg::ST_TS:    begin mul_a = st_q;  mul_b = TW'(g_q);     end
      eps_pkg::ST_GS:    begin mul_a = t_q;   mul_b = TW'(rd_gain); end
      eps_pkg::ST_FMUL:  begin mul_a = per_q; mul_b = flicker_q;    end
      default:           begin mul_a = t_q;   mul_b = TW'(g_q);     end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign reached = (prod >= (2*TW)'(ev_q));

  eps_pkg::div_req_t div_req;
  eps_pkg::div_rsp_t div_rsp;

  eps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic out_valid_q;
  logic out_free;
  eps_pkg::out_item_t out_q;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eps_pkg::ST_IDLE:
        if (in_acc && (in_item_i.command == eps_pkg::CMD_SPLIT)) state_d = eps_pkg::ST_INIT;
      eps_pkg::ST_INIT:  state_d = eps_pkg::ST_CHK;
      eps_pkg::ST_CHK:
        if (reached || (ft_nz && fg_nz)) state_d = eps_pkg::ST_FLK;
        else                             state_d = eps_pkg::ST_LOOP;
      eps_pkg::ST_LOOP:
        if (s_q >= nst)   state_d = eps_pkg::ST_FLK;
        else if (!ft_nz)  state_d = eps_pkg::ST_TRD;
        else              state_d = eps_pkg::ST_GS;
      eps_pkg::ST_TRD:   state_d = eps_pkg::ST_TS;
      eps_pkg::ST_TS:
        if (reached)      state_d = eps_pkg::ST_DIVT;
        else if (!fg_nz)  state_d = eps_pkg::ST_GS;
        else              state_d = eps_pkg::ST_LOOP;
      eps_pkg::ST_GS:
        if (reached) state_d = eps_pkg::ST_DIVG;
        else         state_d = eps_pkg::ST_LOOP;
      eps_pkg::ST_DIVT:
        if (div_rsp.done) state_d = eps_pkg::ST_FLK;
      eps_pkg::ST_DIVG:
        if (div_rsp.done) state_d = eps_pkg::ST_FLK;
      eps_pkg::ST_FLK:
        if (!ft_nz && !fg_nz && (flicker_q != '0)) state_d = eps_pkg::ST_FDIV1;
        else                                       state_d = eps_pkg::ST_OUT;
      eps_pkg::ST_FDIV1:
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) state_d = eps_pkg::ST_OUT;
          else                        state_d = eps_pkg::ST_FMUL;
        end
      eps_pkg::ST_FMUL:  state_d = eps_pkg::ST_FMUL2;
      eps_pkg::ST_FMUL2: state_d = eps_pkg::ST_FDIV2;
      eps_pkg::ST_FDIV2:
        if (div_rsp.done) state_d = eps_pkg::ST_OUT;
      eps_pkg::ST_OUT:
        if (out_free) state_d = eps_pkg::ST_IDLE;
      default: state_d = eps_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  logic [GW-1:0] ng_sat;

  always_comb begin
    if (div_rsp.quotient > eps_pkg::DIVD_W'({GW{1'b1}})) ng_sat = '1;
    else                                                 ng_sat = div_rsp.quotient[GW-1:0];
    if (ng_sat > last_q) ng_sat = last_q;
  end

  always_comb begin
    ev_d   = ev_q;
    t_d    = t_q;
    g_d    = g_q;
    st_d   = st_q;
    ft_d   = ft_q;
    per_d  = per_q;
    nt_d   = nt_q;
    last_d = last_q;
    s_d    = s_q;
    rd_addr = s_q[IDXW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = eps_pkg::DIVD_W'(ev_q);
    div_req.divisor  = TW'(g_q);
    unique case (state_q)
      eps_pkg::ST_IDLE: ev_d = in_item_i.exposure_value;
      eps_pkg::ST_INIT: begin
        rd_addr = '0;
        ft_d = limit_time(fixed_time_q, min_time_q, max_time_q);
        t_d  = (ft_d != '0) ? ft_d : limit_time(rd_time, min_time_q, max_time_q);
        g_d  = limit_gain(fg_nz ? fixed_gain_q : rd_gain, min_gain_q);
        s_d  = CNTW'(1);
      end
      eps_pkg::ST_TRD: st_d = limit_time(rd_time, min_time_q, max_time_q);
      eps_pkg::ST_TS: begin
        if (reached) begin
          div_req.start = 1'b1;
        end else begin
          t_d = st_q;
          if (fg_nz) s_d = s_q + 1'b1;
        end
      end
      eps_pkg::ST_GS: begin
        if (reached) begin
          div_req.start   = 1'b1;
          div_req.divisor = t_q;
        end else begin
          g_d = limit_gain(rd_gain, min_gain_q);
          s_d = s_q + 1'b1;
        end
      end
      eps_pkg::ST_DIVT: if (div_rsp.done) t_d = div_rsp.quotient[TW-1:0];
      eps_pkg::ST_DIVG: if (div_rsp.done) g_d = div_rsp.quotient[GW-1:0];
      eps_pkg::ST_FLK: begin
        div_req.start    = !ft_nz && !fg_nz && (flicker_q != '0);
        div_req.dividend = eps_pkg::DIVD_W'(t_q);
        div_req.divisor  = flicker_q;
      end
      eps_pkg::ST_FDIV1: if (div_rsp.done) per_d = div_rsp.quotient[TW-1:0];
      eps_pkg::ST_FMUL: begin
        // The product of periods and period never exceeds the time, so it fits.
        rd_addr = last_idx;
        nt_d    = prod[TW-1:0];
        last_d  = rd_gain;
      end
      eps_pkg::ST_FMUL2: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[eps_pkg::DIVD_W-1:0];
        div_req.divisor  = nt_q;
      end
      eps_pkg::ST_FDIV2: begin
        if (div_rsp.done) begin
          g_d = limit_gain(ng_sat, min_gain_q);
          t_d = nt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == eps_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    t_q    <= t_d;
    g_q    <= g_d;
    st_q   <= st_d;
    ft_q   <= ft_d;
    per_q  <= per_d;
    nt_q   <= nt_d;
    last_q <= last_d;
    s_q    <= s_d;
    if (state_q == eps_pkg::ST_OUT && out_free) begin
      out_q.exposure_time <= t_q;
      out_q.analogue_gain <= g_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the exposure profile splitter core.
module tb_top;

  // The run ends in failure if it is still going after this many cycles.
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned RAND_ITEMS  = 225;  // items per random phase
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned SETTLE      = 200;  // cycles to let a split drain

  // A directed row. Where the result is obvious it is typed in; otherwise
  // the predictor supplies it.
  typedef struct {
    eps_pkg::in_item_t  item;
    bit                 typed;
    eps_pkg::out_item_t want;
  } step_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  eps_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  eps_pkg::out_item_t out_item_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  exposure_profile_splitter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow copy of the configuration registers, at their reset values.
  logic [23:0] cfg_fixed_time = '0;
  logic [15:0] cfg_fixed_gain = '0;
  logic [23:0] cfg_flicker    = '0;
  logic [23:0] cfg_min_time   = '0;
  logic [23:0] cfg_max_time   = 24'hFFFFFF;
  logic [15:0] cfg_min_gain   = 16'd256;
  logic [3:0]  cfg_stages     = 4'd2;

  // Shadow copy of the exposure profile.
  logic [23:0] prof_time [8];
  logic [15:0] prof_gain [8];

  // Expected splits, oldest first.
  eps_pkg::out_item_t pending_splits[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned n_splits;
  int unsigned n_loads;
  int unsigned n_results;
  int unsigned send_pct;
  int unsigned recv_pct;
  int unsigned hold_left;

  // The clock runs from time zero; reset is held by the main sequence below.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung block must not keep the run alive forever.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Time limiting: zero passes through untouched, then the minimum wins
  // before the maximum is looked at, so inverted limits favor the minimum.
  function automatic logic [31:0] clip_time(logic [31:0] t);
    if (t == 0) return 0;
    if (t < cfg_min_time) return cfg_min_time;
    if (t > cfg_max_time) return cfg_max_time;
    return t;
  endfunction

  function automatic logic [31:0] clip_gain(logic [31:0] g);
    if (g == 0) return 0;
    if (g < cfg_min_gain) return cfg_min_gain;
    return g;
  endfunction

  // Works out the time and gain that a split of the given exposure yields
  // under the current shadow configuration and profile.
  function automatic eps_pkg::out_item_t split_predict(logic [31:0] ev);
    logic [63:0] e;
    logic [63:0] ng;
    logic [31:0] ft, fg, t, g, st, periods, nt;
    int unsigned n;
    bit          done;
    eps_pkg::out_item_t r;
    e    = {32'd0, ev};
    done = 1'b0;
    n    = (cfg_stages < 2) ? 2 : (cfg_stages > 8) ? 8 : cfg_stages;
    ft   = clip_time({8'd0, cfg_fixed_time});
    fg   = {16'd0, cfg_fixed_gain};
    t    = (ft != 0) ? ft : clip_time({8'd0, prof_time[0]});
    g    = clip_gain((fg != 0) ? fg : {16'd0, prof_gain[0]});

    // Walk the stages: lengthen the time first, then raise the gain.
    if ({32'd0, t} * {32'd0, g} < e) begin
      for (int s = 1; s < n && !done; s++) begin
        if (ft == 0) begin
          st = clip_time({8'd0, prof_time[s]});
          if ({32'd0, st} * {32'd0, g} >= e) begin
            t    = (g != 0) ? 32'(e / g) : 0;
            done = 1'b1;
          end else begin
            t = st;
          end
        end
        if (!done && fg == 0) begin
          if ({48'd0, prof_gain[s]} * {32'd0, t} >= e) begin
            g    = (t != 0) ? 32'(e / t) : 0;
            done = 1'b1;
          end else begin
            g = clip_gain({16'd0, prof_gain[s]});
          end
        end
      end
    end

    // Flicker avoidance: round the time down to whole periods and make up
    // with gain, capped by the last stage in use.
    if (ft == 0 && fg == 0 && cfg_flicker != 0) begin
      periods = t / cfg_flicker;
      if (periods != 0) begin
        nt = periods * cfg_flicker;
        ng = ({32'd0, g} * {32'd0, t}) / nt;
        if (ng > 64'hFFFF) ng = 64'hFFFF;
        if (ng > prof_gain[n-1]) ng = {48'd0, prof_gain[n-1]};
        g = clip_gain(32'(ng));
        t = nt;
      end
    end
    r.exposure_time = t[23:0];
    r.analogue_gain = g[15:0];
    return r;
  endfunction

  // Writes one register through the APB port and mirrors it in the shadow.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      eps_pkg::REG_FIXED_TIME: cfg_fixed_time = val[23:0];
      eps_pkg::REG_FIXED_GAIN: cfg_fixed_gain = val[15:0];
      eps_pkg::REG_FLICKER:    cfg_flicker    = val[23:0];
      eps_pkg::REG_MIN_TIME:   cfg_min_time   = val[23:0];
      eps_pkg::REG_MAX_TIME:   cfg_max_time   = val[23:0];
      eps_pkg::REG_MIN_GAIN:   cfg_min_gain   = val[15:0];
      eps_pkg::REG_STAGES:     cfg_stages     = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [23:0] f_t, logic [15:0] f_g, logic [23:0] flk,
                           logic [23:0] lo_t, logic [23:0] hi_t, logic [15:0] lo_g,
                           logic [3:0] stg);
    reg_write(eps_pkg::REG_FIXED_TIME, {8'd0, f_t});
    reg_write(eps_pkg::REG_FIXED_GAIN, {16'd0, f_g});
    reg_write(eps_pkg::REG_FLICKER, {8'd0, flk});
    reg_write(eps_pkg::REG_MIN_TIME, {8'd0, lo_t});
    reg_write(eps_pkg::REG_MAX_TIME, {8'd0, hi_t});
    reg_write(eps_pkg::REG_MIN_GAIN, {16'd0, lo_g});
    reg_write(eps_pkg::REG_STAGES, {28'd0, stg});
  endtask

  // Offers one item until it is taken, then records what it should cause.
  // When an item is typed in, the predicted result is checked against that value too.
  task automatic offer_item(eps_pkg::in_item_t it, bit typed, eps_pkg::out_item_t want);
    eps_pkg::out_item_t p;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.command == eps_pkg::CMD_LOAD) begin
      prof_time[it.stage_index] = it.stage_time;
      prof_gain[it.stage_index] = it.stage_gain;
      n_loads++;
    end else begin
      p = split_predict(it.exposure_value);
      if (typed && p != want) begin
        $error("typed-in split result disagrees: expected %h, predicted %h", want, p);
        errors++;
      end
      pending_splits.insert(pending_splits.size(), p);
      n_splits++;
    end
    // A random gap after the item; the valid only drops if one is taken.
    if ($urandom_range(99) < send_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      while ($urandom_range(99) < send_pct) @(negedge clk_i);
    end
  endtask

  task automatic go_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic eps_pkg::in_item_t load_item(logic [2:0] idx, logic [23:0] t,
                                                  logic [15:0] g);
    eps_pkg::in_item_t it;
    it                = '0;
    it.command        = eps_pkg::CMD_LOAD;
    it.stage_index    = idx;
    it.stage_time     = t;
    it.stage_gain     = g;
    it.exposure_value = $urandom;
    return it;
  endfunction

  function automatic eps_pkg::in_item_t split_item(logic [31:0] ev);
    eps_pkg::in_item_t it;
    it                = '0;
    it.command        = eps_pkg::CMD_SPLIT;
    it.stage_index    = 3'($urandom);
    it.stage_time     = 24'($urandom);
    it.stage_gain     = 16'($urandom);
    it.exposure_value = ev;
    return it;
  endfunction

  // Receiver: a hold-off requested by the main process is counted down
  // here; otherwise the stall is random at the rate of the current phase.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_splits.size() == 0) begin
        $error("result with no split waiting: time %0d gain %0d",
               out_item_o.exposure_time, out_item_o.analogue_gain);
        errors++;
      end else begin
        if (out_item_o.exposure_time !== pending_splits[0].exposure_time) begin
          $error("exposure_time: expected %0d, got %0d",
                 pending_splits[0].exposure_time, out_item_o.exposure_time);
          errors++;
        end
        if (out_item_o.analogue_gain !== pending_splits[0].analogue_gain) begin
          $error("analogue_gain: expected %0d, got %0d",
                 pending_splits[0].analogue_gain, out_item_o.analogue_gain);
          errors++;
        end
        void'(pending_splits.pop_front());
      end
    end
  end

  // Main sequence: reset, a directed table at the default settings, then
  // random phases that each start from a new register setting and idling mode.
  initial begin
    step_row_t         rows[$];
    step_row_t         row;
    eps_pkg::in_item_t it;
    logic [23:0]       t_acc;
    logic [15:0]       g_acc;
    int unsigned       sel;
    errors      = 0;
    n_splits    = 0;
    n_loads     = 0;
    n_results   = 0;
    send_pct    = 0;
    recv_pct    = 0;
    hold_left   = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Every stage is loaded first, so that no split ever
    // reads a stage that was never written.
    row.typed = 1'b0;
    row.want  = '0;
    row.item = load_item(3'd0, 24'd1000, 16'd256);    rows.insert(rows.size(), row);
    row.item = load_item(3'd1, 24'd10000, 16'd1024);  rows.insert(rows.size(), row);
    for (int i = 2; i < 8; i++) begin
      row.item = load_item(i[2:0], 24'(10000 * (i + 1)), 16'(1024 * i));
      rows.insert(rows.size(), row);
    end
    // Zero request: the first stage already covers it.
    row.typed = 1'b1;
    row.item  = split_item(32'd0);
    row.want  = '{exposure_time: 24'd1000, analogue_gain: 16'd256};
    rows.insert(rows.size(), row);
    // Largest request: both stages in use run out, giving the last stage.
    row.item = split_item(32'hFFFF_FFFF);
    row.want = '{exposure_time: 24'd10000, analogue_gain: 16'd1024};
    rows.insert(rows.size(), row);
    row.typed = 1'b0;
    row.item = split_item(32'd256000 + 1);  rows.insert(rows.size(), row);
    row.item = split_item(32'd5_000_000);   rows.insert(rows.size(), row);
    // Zero time and gain in the first stage pass the limits untouched.
    row.item = load_item(3'd0, 24'd0, 16'd0);  rows.insert(rows.size(), row);
    row.item = split_item(32'd0);              rows.insert(rows.size(), row);
    row.item = split_item(32'd12345);          rows.insert(rows.size(), row);
    // Largest stage values.
    row.item = load_item(3'd1, 24'hFFFFFF, 16'hFFFF);  rows.insert(rows.size(), row);
    row.item = split_item(32'hFFFF_FFFF);              rows.insert(rows.size(), row);
    row.item = split_item(32'h8000_0000);              rows.insert(rows.size(), row);
    row.item = load_item(3'd0, 24'd1000, 16'd256);     rows.insert(rows.size(), row);
    row.item = load_item(3'd1, 24'd10000, 16'd1024);   rows.insert(rows.size(), row);
    row.item = split_item(32'd3_000_000);              rows.insert(rows.size(), row);
    foreach (rows[i]) offer_item(rows[i].item, rows[i].typed, rows[i].want);
    go_quiet();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        // 50 Hz flicker, a realistic time window, all eight stages.
        0: write_all(24'd0, 16'd0, 24'd10000, 24'd100, 24'd66666, 16'd256, 4'd8);
        1: write_all(24'd5000, 16'd0, 24'd10000, 24'd20, 24'd40000, 16'd128, 4'd5);
        2: write_all(24'd0, 16'd512, 24'd8333, 24'd0, 24'd30000, 16'd256, 4'd1);
        // Both fixed, and a stage count below the legal range.
        3: write_all(24'd70000, 16'd300, 24'd8333, 24'd50, 24'd60000, 16'd256, 4'd0);
        // Inverted limits, no minimum gain, a stage count above the range.
        4: write_all(24'd0, 16'd0, 24'd8333, 24'd50000, 24'd1000, 16'd0, 4'd15);
        // Extremes of every register.
        5: write_all(24'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 4'd8);
        6: write_all(24'hFFFFFF, 16'hFFFF, 24'd0, 24'd0, 24'd0, 16'd0, 4'd9);
        default: write_all(24'($urandom_range(0, 1)), 16'd0, 24'($urandom_range(1, 20000)),
                           24'($urandom_range(0, 500)), 24'($urandom_range(500, 200000)),
                           16'($urandom_range(0, 1024)), 4'($urandom_range(2, 8)));
      endcase
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 86; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 86; end
        default: begin send_pct = 27; recv_pct = 27; end
      endcase
      // One long hold-off: the output register fills, and the block must
      // stall its input while the sender keeps offering splits.
      if (ph == 0) hold_left = 600;

      // A fresh, well-formed profile: times and gains never fall from stage to stage.
      t_acc = 24'($urandom_range(50, 2000));
      g_acc = 16'($urandom_range(128, 400));
      for (int i = 0; i < 8; i++) begin
        offer_item(load_item(i[2:0], t_acc, g_acc), 1'b0, '0);
        t_acc = t_acc + 24'($urandom_range(0, 20000));
        g_acc = g_acc + 16'($urandom_range(0, 1500));
      end

      for (int k = 0; k < RAND_ITEMS; k++) begin
        sel = $urandom_range(99);
        if (sel < 8) begin
          // A stage rewritten with arbitrary contents, now and then extreme.
          it = load_item(3'($urandom), 24'($urandom), 16'($urandom));
          if (sel < 2) it.stage_time = (sel == 0) ? 24'd0 : 24'hFFFFFF;
          if (sel == 3) it.stage_gain = 16'hFFFF;
          if (sel == 4) it.stage_gain = 16'd0;
        end else if (sel < 14) begin
          it = load_item(3'($urandom), 24'($urandom_range(1, 200000)),
                         16'($urandom_range(256, 8192)));
        end else begin
          case ($urandom_range(4))
            0: it = split_item($urandom);
            1: it = split_item(32'($urandom_range(0, 1023)));
            2: it = split_item(32'($urandom_range(0, 32'h00FF_FFFF)));
            3: it = split_item(32'($urandom_range(32'h0100_0000, 32'h2000_0000)));
            default: it = split_item(($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0);
          endcase
        end
        offer_item(it, 1'b0, '0);
      end
      go_quiet();
    end

    if (pending_splits.size() != 0) begin
      $error("%0d splits never produced a result", pending_splits.size());
      errors++;
    end
    $display("Covered %0d splits and %0d profile loads over %0d register settings,",
             n_splits, n_loads, NUM_PHASES + 1);
    $display("with %0d results checked and %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
